[hdl/hbrc_pkg.sv]
package hbrc_pkg;

    localparam int NUM_BINS = 64;
    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int DATA_W   = 32;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // register select, address bit 2 of the configuration port
    localparam logic REG_CEILING   = 1'b0;
    localparam logic REG_BIN_WIDTH = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_READ,
        OP_CLEAR
    } hbrc_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SUM,
        ST_SUM_END,
        ST_EMIT_RD,
        ST_EMIT_LD
    } hbrc_state_t;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [DATA_W-1:0]        sample_value;
        logic signed [DATA_W-1:0] add_amount;
    } hbrc_in_t;

    typedef struct packed {
        logic [DATA_W-1:0]        bin_start;
        logic signed [DATA_W-1:0] bin_count;
        logic signed [DATA_W-1:0] tail_sum;
        logic                     last;
    } hbrc_out_t;

    typedef struct packed {
        hbrc_op_t          op;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] amount;
    } hbrc_job_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } hbrc_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } hbrc_div_rsp_t;

endpackage

[hdl/hbrc_ram.sv]
module hbrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/hbrc_div.sv]
module hbrc_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hbrc_pkg::hbrc_div_req_t req,
    output hbrc_pkg::hbrc_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(hbrc_pkg::DATA_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [hbrc_pkg::DATA_W-1:0] rem_reg, rem_next;
    logic [hbrc_pkg::DATA_W-1:0] quo_reg, quo_next;
    logic [hbrc_pkg::DATA_W-1:0] dvs_reg, dvs_next;
    logic [hbrc_pkg::DATA_W:0]   shifted;
    logic [hbrc_pkg::DATA_W:0]   diff;
    logic                        fits;

    // one restoring step: dividend bits shift out of quo_reg as quotient bits shift in
    assign shifted = {rem_reg, quo_reg[hbrc_pkg::DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = !diff[hbrc_pkg::DATA_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[hbrc_pkg::DATA_W-1:0] : shifted[hbrc_pkg::DATA_W-1:0];
            quo_next = {quo_reg[hbrc_pkg::DATA_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(hbrc_pkg::DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !req.start && (cnt_reg == CNT_W'(hbrc_pkg::DATA_W - 1)) |=> done_reg)
        else $error("divider finished its steps without done");

endmodule

[hdl/hbrc_front.sv]
module hbrc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  hbrc_pkg::hbrc_in_t          in_data,
    input  logic [hbrc_pkg::DATA_W-1:0] value_ceiling,
    output logic                        job_valid,
    output hbrc_pkg::hbrc_job_t         job,
    input  logic                        job_pop
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    hbrc_pkg::hbrc_job_t queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    hbrc_pkg::hbrc_job_t new_job;
    logic                keep;
    logic                accept;
    logic                push;

    // sort the transaction: out-of-range adds and unused codes never reach the queue
    always_comb
    begin
        new_job.op     = hbrc_pkg::OP_ADD;
        new_job.value  = in_data.sample_value;
        new_job.amount = in_data.add_amount;
        keep           = 1'b0;
        unique case (in_data.cmd)
            hbrc_pkg::CMD_ADD:
            begin
                keep = (in_data.sample_value <= value_ceiling);
            end
            hbrc_pkg::CMD_READ:
            begin
                new_job.op = hbrc_pkg::OP_READ;
                keep       = 1'b1;
            end
            hbrc_pkg::CMD_CLEAR:
            begin
                new_job.op = hbrc_pkg::OP_CLEAR;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign accept    = in_valid && !in_stall;
    assign push      = accept && keep;
    assign job_valid = (count_reg != '0);
    assign job       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (job_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !job_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && job_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_job;
        end
    end

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (count_reg != '0))
        else $error("job queue popped while empty");

endmodule

[hdl/hbrc_back.sv]
module hbrc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    input  hbrc_pkg::hbrc_job_t         job,
    output logic                        job_pop,
    input  logic [hbrc_pkg::DATA_W-1:0] value_ceiling,
    input  logic [hbrc_pkg::DATA_W-1:0] bin_width_eff,
    output hbrc_pkg::hbrc_div_req_t     div_req,
    input  hbrc_pkg::hbrc_div_rsp_t     div_rsp,
    output logic                        out_valid,
    input  logic                        out_stall,
    output hbrc_pkg::hbrc_out_t         out_data
);

    localparam logic [hbrc_pkg::BIN_W-1:0] TOP_MAX = hbrc_pkg::BIN_W'(hbrc_pkg::NUM_BINS - 1);

    hbrc_pkg::hbrc_state_t         state_reg, state_next;
    logic [hbrc_pkg::BIN_W-1:0]    idx_reg, idx_next;
    logic [hbrc_pkg::BIN_W-1:0]    top_reg, top_next;
    logic                          is_read_reg, is_read_next;
    logic                          pend_reg, pend_next;
    logic [hbrc_pkg::DATA_W-1:0]   amount_reg, amount_next;
    logic [hbrc_pkg::DATA_W-1:0]   total_reg, total_next;
    logic [hbrc_pkg::DATA_W-1:0]   tail_reg, tail_next;
    logic [hbrc_pkg::DATA_W-1:0]   start_reg, start_next;
    logic [hbrc_pkg::NUM_BINS-1:0] valid_reg, valid_next;
    logic                          rd_valid_reg;
    logic                          out_valid_reg, out_valid_next;
    hbrc_pkg::hbrc_out_t           out_data_reg, out_data_next;

    logic                          ram_we;
    logic [hbrc_pkg::DATA_W-1:0]   ram_wdata;
    logic [hbrc_pkg::DATA_W-1:0]   ram_rdata;
    logic [hbrc_pkg::DATA_W-1:0]   rd_val;
    logic                          out_free;
    logic                          in_range;
    logic                          at_top;

    // the store is always read at the current bin; the read data is registered and comes back in the next cycle
    hbrc_ram #(
        .WIDTH (hbrc_pkg::DATA_W),
        .DEPTH (hbrc_pkg::NUM_BINS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // a bin never written since the last clear reads as zero
    assign rd_val   = rd_valid_reg ? ram_rdata : '0;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_range = (div_rsp.quotient < hbrc_pkg::DATA_W'(hbrc_pkg::NUM_BINS));
    assign at_top   = (idx_reg == top_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hbrc_pkg::ST_IDLE:
            begin
                if (job_valid && (job.op != hbrc_pkg::OP_CLEAR))
                begin
                    state_next = hbrc_pkg::ST_DIV;
                end
            end
            hbrc_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (is_read_reg)
                    begin
                        state_next = hbrc_pkg::ST_SUM;
                    end
                    else if (in_range)
                    begin
                        state_next = hbrc_pkg::ST_ADD_RD;
                    end
                    else
                    begin
                        state_next = hbrc_pkg::ST_IDLE;
                    end
                end
            end
            hbrc_pkg::ST_ADD_RD:
            begin
                state_next = hbrc_pkg::ST_ADD_WR;
            end
            hbrc_pkg::ST_ADD_WR:
            begin
                state_next = hbrc_pkg::ST_IDLE;
            end
            hbrc_pkg::ST_SUM:
            begin
                if (at_top)
                begin
                    state_next = hbrc_pkg::ST_SUM_END;
                end
            end
            hbrc_pkg::ST_SUM_END:
            begin
                state_next = hbrc_pkg::ST_EMIT_RD;
            end
            hbrc_pkg::ST_EMIT_RD:
            begin
                state_next = hbrc_pkg::ST_EMIT_LD;
            end
            hbrc_pkg::ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = at_top ? hbrc_pkg::ST_IDLE : hbrc_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = hbrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        top_next       = top_reg;
        is_read_next   = is_read_reg;
        pend_next      = pend_reg;
        amount_next    = amount_reg;
        total_next     = total_reg;
        tail_next      = tail_reg;
        start_next     = start_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            hbrc_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    is_read_next = (job.op == hbrc_pkg::OP_READ);
                    amount_next  = job.amount;
                    if (job.op == hbrc_pkg::OP_CLEAR)
                    begin
                        valid_next = '0;
                    end
                end
            end
            hbrc_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (is_read_reg)
                    begin
                        // top bin in use, capped at the last bin of the store
                        top_next   = (div_rsp.quotient >= hbrc_pkg::DATA_W'(hbrc_pkg::NUM_BINS - 1))
                                   ? TOP_MAX : div_rsp.quotient[hbrc_pkg::BIN_W-1:0];
                        idx_next   = '0;
                        total_next = '0;
                        pend_next  = 1'b0;
                    end
                    else
                    begin
                        idx_next = div_rsp.quotient[hbrc_pkg::BIN_W-1:0];
                    end
                end
            end
            hbrc_pkg::ST_ADD_RD:
            begin
            end
            hbrc_pkg::ST_ADD_WR:
            begin
                valid_next[idx_reg] = 1'b1;
            end
            hbrc_pkg::ST_SUM:
            begin
                // first pass: total of all bins in use, one read per cycle
                if (pend_reg)
                begin
                    total_next = total_reg + rd_val;
                end
                pend_next = 1'b1;
                if (!at_top)
                begin
                    idx_next = idx_reg + hbrc_pkg::BIN_W'(1);
                end
            end
            hbrc_pkg::ST_SUM_END:
            begin
                tail_next  = total_reg + rd_val;
                idx_next   = '0;
                start_next = '0;
            end
            hbrc_pkg::ST_EMIT_RD:
            begin
            end
            hbrc_pkg::ST_EMIT_LD:
            begin
                // second pass: tail sum is the total less every bin below this one
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.bin_start = start_reg;
                    out_data_next.bin_count = rd_val;
                    out_data_next.tail_sum  = tail_reg;
                    out_data_next.last      = at_top;
                    tail_next               = tail_reg - rd_val;
                    start_next              = start_reg + bin_width_eff;
                    if (!at_top)
                    begin
                        idx_next = idx_reg + hbrc_pkg::BIN_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        job_pop          = (state_reg == hbrc_pkg::ST_IDLE) && job_valid;
        div_req.start    = job_pop && (job.op != hbrc_pkg::OP_CLEAR);
        div_req.dividend = (job.op == hbrc_pkg::OP_READ) ? value_ceiling : job.value;
        div_req.divisor  = bin_width_eff;
        ram_we           = (state_reg == hbrc_pkg::ST_ADD_WR);
        ram_wdata        = rd_val + amount_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbrc_pkg::ST_IDLE;
            idx_reg       <= '0;
            top_reg       <= '0;
            is_read_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            top_reg       <= top_next;
            is_read_reg   <= is_read_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            rd_valid_reg  <= valid_reg[idx_reg];
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amount_reg   <= amount_next;
        total_reg    <= total_next;
        tail_reg     <= tail_next;
        start_reg    <= start_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_sum_within_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hbrc_pkg::ST_SUM) |-> (idx_reg <= top_reg))
        else $error("summing pass ran past the top bin");

    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == hbrc_pkg::ST_DIV))
        else $error("quotient arrived while nothing waited for it");

endmodule

[hdl/binned_histogram_reverse_cdf_unit.sv]
// add: job queue, 32-step serial divider, read-modify-write of the bin store; an add is
//   done before the next job is popped; a 2-deep job queue takes new transactions
// readout: the divider finds the top bin in use, a summing pass adds up each bin in use,
//   then the rows go out from bin 0 up, held by out_stall; clear: drops the valid flags
// reset: bin store reads as zero at once (per-bin valid flags), value ceiling 63, bin width 1
module binned_histogram_reverse_cdf_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  hbrc_pkg::hbrc_in_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output hbrc_pkg::hbrc_out_t         out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [hbrc_pkg::DATA_W-1:0] pwdata,
    output logic [hbrc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    logic [hbrc_pkg::DATA_W-1:0] ceiling_reg, ceiling_next;
    logic [hbrc_pkg::DATA_W-1:0] bin_width_reg, bin_width_next;
    logic [hbrc_pkg::DATA_W-1:0] bin_width_eff;
    logic                        cfg_write;
    logic                        job_valid;
    hbrc_pkg::hbrc_job_t         job;
    logic                        job_pop;
    hbrc_pkg::hbrc_div_req_t     div_req;
    hbrc_pkg::hbrc_div_rsp_t     div_rsp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        ceiling_next   = ceiling_reg;
        bin_width_next = bin_width_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                hbrc_pkg::REG_CEILING:   ceiling_next   = pwdata;
                hbrc_pkg::REG_BIN_WIDTH: bin_width_next = pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            hbrc_pkg::REG_CEILING:   prdata = ceiling_reg;
            hbrc_pkg::REG_BIN_WIDTH: prdata = bin_width_reg;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg   <= hbrc_pkg::DATA_W'(63);
            bin_width_reg <= hbrc_pkg::DATA_W'(1);
        end
        else
        begin
            ceiling_reg   <= ceiling_next;
            bin_width_reg <= bin_width_next;
        end
    end

    // zero bin width counts as one
    assign bin_width_eff = (bin_width_reg == '0) ? hbrc_pkg::DATA_W'(1) : bin_width_reg;

    hbrc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .value_ceiling (ceiling_reg),
        .job_valid     (job_valid),
        .job           (job),
        .job_pop       (job_pop)
    );

    hbrc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    hbrc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job           (job),
        .job_pop       (job_pop),
        .value_ceiling (ceiling_reg),
        .bin_width_eff (bin_width_eff),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

endmodule

[bench/binned_histogram_reverse_cdf_unit_test.sv]
module binned_histogram_reverse_cdf_unit_test;

    localparam int CLOCK_HALF      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int QUIET_CYCLES    = 160;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 37;
    localparam int IDLE_PERCENT    = 68;
    localparam int BOTH_PERCENT    = 26;

    // the one command code the block leaves unused
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    class hist_tracker;
        logic [hbrc_pkg::DATA_W-1:0] bin_tally [hbrc_pkg::NUM_BINS];
        logic [hbrc_pkg::DATA_W-1:0] value_ceiling;
        logic [hbrc_pkg::DATA_W-1:0] bin_width;
        hbrc_pkg::hbrc_out_t         pending_rows [$];
        int                          errors;
        int                          rows_checked;
        int                          items_noted;

        function void clear_bins();
            foreach (bin_tally[i])
                bin_tally[i] = '0;
        endfunction

        function void reset_state();
            clear_bins();
            value_ceiling = 32'd63;
            bin_width     = 32'd1;
            pending_rows.delete();
            errors       = 0;
            rows_checked = 0;
            items_noted  = 0;
        endfunction

        function void set_reg(logic idx, logic [hbrc_pkg::DATA_W-1:0] value);
            if (idx == hbrc_pkg::REG_CEILING)
                value_ceiling = value;
            else if (idx == hbrc_pkg::REG_BIN_WIDTH)
                bin_width = value;
        endfunction

        function logic [hbrc_pkg::DATA_W-1:0] eff_size();
            return (bin_width == '0) ? 32'd1 : bin_width;
        endfunction

        function int unsigned bins_in_use();
            longint unsigned n;
            n = value_ceiling / eff_size();
            n = n + 1;
            if (n > hbrc_pkg::NUM_BINS)
                n = hbrc_pkg::NUM_BINS;
            return 32'(n);
        endfunction

        function void note_item(hbrc_pkg::hbrc_in_t t);
            logic [hbrc_pkg::DATA_W-1:0] acc;
            logic [hbrc_pkg::DATA_W-1:0] idx;
            hbrc_pkg::hbrc_out_t         rows [hbrc_pkg::NUM_BINS];
            int                          n;
            items_noted++;
            case (t.cmd)
                hbrc_pkg::CMD_ADD:
                begin
                    if (t.sample_value <= value_ceiling)
                    begin
                        idx = t.sample_value / eff_size();
                        if (idx < hbrc_pkg::NUM_BINS)
                            bin_tally[idx] += t.add_amount;
                    end
                end
                hbrc_pkg::CMD_READ:
                begin
                    n   = bins_in_use();
                    acc = '0;
                    // tail sums run from the top bin down, rows go out from bin 0 up
                    for (int i = n - 1; i >= 0; i--)
                    begin
                        acc += bin_tally[i];
                        rows[i].bin_start = 32'(i) * eff_size();
                        rows[i].bin_count = bin_tally[i];
                        rows[i].tail_sum  = acc;
                        rows[i].last      = (i == n - 1);
                    end
                    for (int i = 0; i < n; i++)
                        pending_rows.push_back(rows[i]);
                end
                hbrc_pkg::CMD_CLEAR:
                    clear_bins();
                default:
                    ;
            endcase
        endfunction

        function void check_row(hbrc_pkg::hbrc_out_t got);
            hbrc_pkg::hbrc_out_t want;
            if (pending_rows.size() == 0)
            begin
                $error("unexpected result row: bin_start %0d bin_count %0d tail_sum %0d last %0b",
                       got.bin_start, got.bin_count, got.tail_sum, got.last);
                errors++;
                return;
            end
            want = pending_rows.pop_front();
            rows_checked++;
            if (got.bin_start !== want.bin_start)
            begin
                $error("bin_start: expected %0d, got %0d", want.bin_start, got.bin_start);
                errors++;
            end
            if (got.bin_count !== want.bin_count)
            begin
                $error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
                errors++;
            end
            if (got.tail_sum !== want.tail_sum)
            begin
                $error("tail_sum: expected %0d, got %0d", want.tail_sum, got.tail_sum);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    hbrc_pkg::hbrc_in_t          in_data   = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    hbrc_pkg::hbrc_out_t         out_data;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [2:0]                  paddr     = '0;
    logic [hbrc_pkg::DATA_W-1:0] pwdata    = '0;
    logic [hbrc_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    idle_mode_t  idle_mode = IDLE_NONE;
    hist_tracker tracker;
    int          cycle_count;

    logic [hbrc_pkg::DATA_W-1:0] phase_ceiling [NUM_PHASES] =
        '{32'd63, 32'd255, 32'hFFFF_FFFF, 32'd9, 32'hFFFF_FFFF, 32'd0, 32'd1000};
    logic [hbrc_pkg::DATA_W-1:0] phase_width [NUM_PHASES] =
        '{32'd1, 32'd4, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'd7, 32'd100};
    idle_mode_t phase_mode [NUM_PHASES] =
        '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_RECEIVER, IDLE_BOTH,
          IDLE_SENDER};

    binned_histogram_reverse_cdf_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #CLOCK_HALF clk = ~clk;

    // result side: check each accepted result row, then pick the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                tracker.check_row(out_data);
            out_stall <= (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH)
                         && ($urandom_range(0, 99)
                             < ((idle_mode == IDLE_BOTH) ? BOTH_PERCENT : IDLE_PERCENT));
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_item(input hbrc_pkg::hbrc_in_t t);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_BOTH) ? BOTH_PERCENT : IDLE_PERCENT;
        while ((idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH)
               && ($urandom_range(0, 99) < idle_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_item(t);
    endtask

    task automatic send_fields(input logic [1:0] cmd, input logic [hbrc_pkg::DATA_W-1:0] value,
                               input logic [hbrc_pkg::DATA_W-1:0] amount);
        hbrc_pkg::hbrc_in_t t;
        t.cmd          = cmd;
        t.sample_value = value;
        t.add_amount   = amount;
        send_item(t);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_rows.size() != 0)
            @(posedge clk);
    endtask

    // adds and clears leave nothing to wait for, so give the job queue time to empty
    task automatic quiesce();
        drain_results();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [hbrc_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // read back through the same port
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
        begin
            $error("prdata: expected %0h, got %0h", value, prdata);
            tracker.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_reg(idx, value);
        @(posedge clk);
    endtask

    function automatic hbrc_pkg::hbrc_in_t random_item();
        hbrc_pkg::hbrc_in_t t;
        int unsigned        pick;
        longint unsigned    step;
        longint unsigned    v;
        pick           = $urandom_range(0, 99);
        t.cmd          = hbrc_pkg::CMD_ADD;
        t.sample_value = $urandom;
        t.add_amount   = $urandom;
        if (pick < 74)
        begin
            if (pick < 60)
            begin
                // aim inside a bin in use
                step = tracker.eff_size();
                v    = $urandom_range(0, tracker.bins_in_use() - 1);
                v    = v * step + ($urandom % step);
                if (v > tracker.value_ceiling)
                    v = tracker.value_ceiling;
                t.sample_value = v[31:0];
            end
            if ($urandom_range(0, 3) == 0)
                t.add_amount = $urandom_range(0, 20) - 10;
        end
        else if (pick < 88)
            t.cmd = hbrc_pkg::CMD_READ;
        else if (pick < 92)
            t.cmd = hbrc_pkg::CMD_CLEAR;
        else
            t.cmd = CMD_SPARE;
        return t;
    endfunction

    initial
    begin
        hbrc_pkg::hbrc_in_t item;
        int                 sent;
        tracker = new();
        tracker.reset_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: counts wrap both ways, values above the ceiling are ignored
        send_fields(hbrc_pkg::CMD_ADD, 32'd0, 32'h7FFF_FFFF);
        send_fields(hbrc_pkg::CMD_ADD, 32'd0, 32'd1);
        send_fields(hbrc_pkg::CMD_ADD, 32'd63, 32'h8000_0000);
        send_fields(hbrc_pkg::CMD_ADD, 32'd64, 32'd5);
        send_fields(hbrc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h1234_5678);
        send_fields(CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(hbrc_pkg::CMD_READ, 32'd0, 32'd0);
        send_fields(hbrc_pkg::CMD_ADD, 32'd10, 32'hFFFF_FFFF);
        send_fields(hbrc_pkg::CMD_CLEAR, 32'd0, 32'd0);
        send_fields(hbrc_pkg::CMD_READ, 32'd0, 32'd0);
        send_fields(hbrc_pkg::CMD_ADD, 32'd1, 32'h5555_5555);
        send_fields(hbrc_pkg::CMD_ADD, 32'd62, 32'hAAAA_AAAA);

        // zero bin width, bin indices past the top are dropped
        quiesce();
        write_register(hbrc_pkg::REG_CEILING, 32'hFFFF_FFFF);
        write_register(hbrc_pkg::REG_BIN_WIDTH, 32'd0);
        send_fields(hbrc_pkg::CMD_ADD, 32'd1000, 32'd9);
        send_fields(hbrc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'd1);
        send_fields(hbrc_pkg::CMD_ADD, 32'd2, 32'd3);
        send_fields(hbrc_pkg::CMD_READ, 32'd0, 32'd0);

        // single bin in use
        quiesce();
        write_register(hbrc_pkg::REG_CEILING, 32'd0);
        send_fields(hbrc_pkg::CMD_READ, 32'd0, 32'd0);

        // widest bins: two in use
        quiesce();
        write_register(hbrc_pkg::REG_CEILING, 32'hFFFF_FFFF);
        write_register(hbrc_pkg::REG_BIN_WIDTH, 32'hFFFF_FFFF);
        send_fields(hbrc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'd4);
        send_fields(hbrc_pkg::CMD_READ, 32'd0, 32'd0);

        // back to the reset values, the stored counts must still be there
        quiesce();
        write_register(hbrc_pkg::REG_CEILING, 32'd63);
        write_register(hbrc_pkg::REG_BIN_WIDTH, 32'd1);
        send_fields(hbrc_pkg::CMD_READ, 32'd0, 32'd0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            quiesce();
            write_register(hbrc_pkg::REG_CEILING, phase_ceiling[p]);
            write_register(hbrc_pkg::REG_BIN_WIDTH, phase_width[p]);
            idle_mode <= phase_mode[p];
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                item = random_item();
                send_item(item);
                if (item.cmd != CMD_SPARE)
                    sent++;
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
        end

        quiesce();
        $display("histogram run: %0d transactions in, %0d result rows checked",
                 tracker.items_noted, tracker.rows_checked);
        $display("settings spanned bin widths 0 to all-ones and ceilings 0 to all-ones");
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
